### hw/rtl/moe_dlc_pkg.sv
`timescale 1ns / 1ps

package moe_dlc_pkg;

   // input item kinds
   typedef enum logic [1:0] {
      KIND_ROUTE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // register indexes
   localparam logic CSR_EXPERT_TOTAL = 1'b0;
   localparam logic CSR_RANK_TOTAL   = 1'b1;

   localparam logic [8:0] EXPERT_TOTAL_RESET = 9'd256;
   localparam logic [4:0] RANK_TOTAL_RESET   = 5'd16;

   localparam int DIV_BITS    = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // commands handed from front to back
   typedef enum logic [1:0] {
      OP_ROUTE,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       upd;         // counters get bumped
      logic       err;         // choice was out of range
      logic       token_end;
      logic [7:0] expert_sel;
      logic [7:0] rank_idx;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_PER_WAIT,
      F_RANK_WAIT
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_EXEC,
      B_CLEAR
   } back_state_type;

endpackage

### hw/rtl/moe_dlc_req_if.sv
`timescale 1ns / 1ps

interface moe_dlc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic signed [8:0] expert_choice;
   logic              token_end;
   logic [7:0]        read_index;

   modport source (output valid, kind, expert_choice, token_end, read_index, input ready);
   modport sink   (input valid, kind, expert_choice, token_end, read_index, output ready);
endinterface

### hw/rtl/moe_dlc_rsp_if.sv
`timescale 1ns / 1ps

interface moe_dlc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rank_mask;
   logic        mask_valid;
   logic [31:0] expert_tally;
   logic [31:0] rank_tally;
   logic        range_error;

   modport source (output valid, rank_mask, mask_valid, expert_tally, rank_tally,
                   range_error, input ready);
   modport sink   (input valid, rank_mask, mask_valid, expert_tally, rank_tally,
                   range_error, output ready);
endinterface

### hw/rtl/moe_dispatch_layout_counter_top.sv
`timescale 1ns / 1ps

// MoE dispatch layout counter. Takes routing choices, counter reads and counter clears
// on req_ch and returns token rank masks and counter reads on rsp_ch. A front end
// classifies items and finds each choice's rank with a serial divider; a
// 4-entry command queue feeds a back end that does read-modify-write on the counter
// memories. A valid choice holds the front end until the divider is done; an empty
// or bad choice, a read or a clear bypasses the divider. The back end takes its next
// item only when done with the last. A clear, and reset, sweeps the counters one
// entry a cycle, during which the queue still fills. A register write recomputes
// experts per rank before the next item is taken.
module moe_dispatch_layout_counter_top #(
   parameter int MAX_EXPERTS = 256,
   parameter int MAX_RANKS   = 16,
   parameter int COUNT_BITS  = 32
) (
   input logic         clock,
   input logic         reset,
   moe_dlc_req_if.sink req_ch,
   moe_dlc_rsp_if.source rsp_ch,
   input logic         csr_we,
   input logic         csr_index,
   input logic [8:0]   csr_wdata
);
   import moe_dlc_pkg::*;

   logic    q_full, q_push, q_pop, q_empty;
   cmd_type q_data, q_head;

   moe_dlc_front #(
      .MAX_EXPERTS (MAX_EXPERTS),
      .MAX_RANKS   (MAX_RANKS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   moe_dlc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   moe_dlc_back #(
      .MAX_EXPERTS (MAX_EXPERTS),
      .MAX_RANKS   (MAX_RANKS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .rsp_ch  (rsp_ch)
   );

endmodule

### hw/rtl/moe_dlc_div.sv
`timescale 1ns / 1ps

module moe_dlc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [moe_dlc_pkg::DIV_BITS-1:0] dividend,
   input  logic [moe_dlc_pkg::DIV_BITS-1:0] divisor,
   output logic                            done,
   output logic [moe_dlc_pkg::DIV_BITS-1:0] quotient
);
   import moe_dlc_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0] dvs_ff, dvs_in;
   logic [DIV_BITS:0]   rem_sh;
   logic [DIV_BITS:0]   diff;
   logic                ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_BITS-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIV_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/moe_dlc_fifo.sv
`timescale 1ns / 1ps

module moe_dlc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  moe_dlc_pkg::cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output moe_dlc_pkg::cmd_type head,
   output logic                 empty
);
   import moe_dlc_pkg::*;

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue read while empty");

endmodule

### hw/rtl/moe_dlc_front.sv
`timescale 1ns / 1ps

module moe_dlc_front #(
   parameter int MAX_EXPERTS = 256,
   parameter int MAX_RANKS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   moe_dlc_req_if.sink          req_ch,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [8:0]           csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output moe_dlc_pkg::cmd_type q_data
);
   import moe_dlc_pkg::*;

   front_state_type     state_ff, state_in;
   logic [8:0]          expert_total_ff;
   logic [4:0]          rank_total_ff;
   logic [DIV_BITS-1:0] per_ff, per_in;
   logic                dirty_ff, dirty_in;   // experts per rank needs recomputing
   cmd_type             pend_ff, pend_in;

   logic                div_start;
   logic [DIV_BITS-1:0] div_dividend;
   logic [DIV_BITS-1:0] div_divisor;
   logic                div_done;
   logic [DIV_BITS-1:0] div_quo;

   logic                choice_neg;
   logic [7:0]          choice_idx;
   logic                route_bad;
   logic                rank_bad;
   cmd_type             acc_cmd;

   moe_dlc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      choice_neg = req_ch.expert_choice[8];
      choice_idx = req_ch.expert_choice[7:0];
      route_bad  = !choice_neg &&
                   (({1'b0, choice_idx} >= expert_total_ff) ||
                    (32'(choice_idx) >= MAX_EXPERTS) ||
                    (rank_total_ff == '0) || (per_ff == '0));
      rank_bad   = (div_quo >= {4'b0, rank_total_ff}) || (32'(div_quo) >= MAX_RANKS);

      acc_cmd            = '0;
      acc_cmd.token_end  = req_ch.token_end;
      acc_cmd.err        = route_bad;
      unique case (kind_type'(req_ch.kind))
         KIND_ROUTE: begin
            acc_cmd.op         = OP_ROUTE;
            acc_cmd.expert_sel = choice_idx;
         end
         KIND_READ: begin
            acc_cmd.op         = OP_READ;
            acc_cmd.expert_sel = req_ch.read_index;
            acc_cmd.rank_idx   = req_ch.read_index;
         end
         KIND_CLEAR: acc_cmd.op = OP_CLEAR;
         KIND_NONE:  acc_cmd.op = OP_CLEAR;
      endcase

      state_in     = state_ff;
      per_in       = per_ff;
      dirty_in     = dirty_ff | csr_we;
      pend_in      = pend_ff;
      q_push       = 1'b0;
      q_data       = acc_cmd;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      req_ch.ready = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            if (dirty_ff) begin
               dirty_in = csr_we;
               if (rank_total_ff == '0) begin
                  per_in = '0;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = expert_total_ff;
                  div_divisor  = {4'b0, rank_total_ff};
                  state_in     = F_PER_WAIT;
               end
            end else begin
               req_ch.ready = !q_full;
               if (req_ch.valid && !q_full) begin
                  unique case (kind_type'(req_ch.kind))
                     KIND_ROUTE: begin
                        if (!choice_neg && !route_bad) begin
                           pend_in      = acc_cmd;
                           div_start    = 1'b1;
                           div_dividend = {1'b0, choice_idx};
                           div_divisor  = per_ff;
                           state_in     = F_RANK_WAIT;
                        end else begin
                           q_push = 1'b1;
                        end
                     end
                     KIND_READ:  q_push = 1'b1;
                     KIND_CLEAR: q_push = 1'b1;
                     KIND_NONE:  q_push = 1'b0;
                  endcase
               end
            end
         end
         F_PER_WAIT: begin
            if (div_done) begin
               per_in   = div_quo;
               state_in = F_IDLE;
            end
         end
         F_RANK_WAIT: begin
            q_data          = pend_ff;
            q_data.rank_idx = div_quo[7:0];
            q_data.upd      = !rank_bad;
            q_data.err      = rank_bad;
            if (div_done) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= F_IDLE;
         expert_total_ff <= EXPERT_TOTAL_RESET;
         rank_total_ff   <= RANK_TOTAL_RESET;
         dirty_ff        <= 1'b1;
         per_ff          <= '0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         per_ff   <= per_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_EXPERT_TOTAL: expert_total_ff <= csr_wdata;
               CSR_RANK_TOTAL:   rank_total_ff   <= csr_wdata[4:0];
            endcase
         end
      end
      pend_ff <= pend_in;
   end

endmodule

### hw/rtl/moe_dlc_back.sv
`timescale 1ns / 1ps

module moe_dlc_back #(
   parameter int MAX_EXPERTS = 256,
   parameter int MAX_RANKS   = 16,
   parameter int COUNT_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  moe_dlc_pkg::cmd_type q_head,
   moe_dlc_rsp_if.source        rsp_ch
);
   import moe_dlc_pkg::*;

   localparam int EXP_AW  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
   localparam int RANK_AW = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam int CLR_N   = (MAX_EXPERTS > MAX_RANKS) ? MAX_EXPERTS : MAX_RANKS;
   localparam int SW_W    = $clog2(CLR_N);

   logic [COUNT_BITS-1:0] expert_mem [MAX_EXPERTS];
   logic [COUNT_BITS-1:0] rank_mem   [MAX_RANKS];

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [MAX_RANKS-1:0]  seen_ff, seen_in;
   logic                  terr_ff, terr_in;
   logic [SW_W-1:0]       sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0] exp_rd_ff;
   logic [COUNT_BITS-1:0] rank_rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_mask_ff;
   logic                  rsp_mvalid_ff;
   logic [31:0]           rsp_et_ff;
   logic [31:0]           rsp_rt_ff;
   logic                  rsp_err_ff;

   logic [31:0]           exp_idx32, rank_idx32, sweep32;
   logic [EXP_AW-1:0]     exp_addr, exp_wa;
   logic [RANK_AW-1:0]    rank_addr, rank_wa;
   logic                  exp_we, rank_we;
   logic [COUNT_BITS-1:0] exp_wd, rank_wd;
   logic                  out_free, out_load;
   logic [15:0]           out_mask;
   logic                  out_mvalid;
   logic [31:0]           out_et, out_rt;
   logic                  out_err;
   logic [MAX_RANKS-1:0]  rank_bit;
   logic [MAX_RANKS-1:0]  seen_next;
   logic [MAX_RANKS+15:0] mask_wide;
   logic                  terr_next;

   always_comb begin
      exp_idx32  = 32'(cmd_ff.expert_sel);
      rank_idx32 = 32'(cmd_ff.rank_idx);
      sweep32    = 32'(sweep_ff);
      exp_addr   = exp_idx32[EXP_AW-1:0];
      rank_addr  = rank_idx32[RANK_AW-1:0];
      out_free   = !rsp_valid_ff || rsp_ch.ready;

      rank_bit            = '0;
      rank_bit[rank_addr] = 1'b1;
      seen_next           = cmd_ff.upd ? (seen_ff | rank_bit) : seen_ff;
      mask_wide           = {16'b0, seen_next};
      terr_next           = terr_ff | cmd_ff.err;

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      seen_in    = seen_ff;
      terr_in    = terr_ff;
      sweep_in   = sweep_ff;
      q_pop      = 1'b0;
      exp_we     = 1'b0;
      rank_we    = 1'b0;
      exp_wa     = exp_addr;
      rank_wa    = rank_addr;
      exp_wd     = (&exp_rd_ff) ? exp_rd_ff : exp_rd_ff + COUNT_BITS'(1);
      rank_wd    = (&rank_rd_ff) ? rank_rd_ff : rank_rd_ff + COUNT_BITS'(1);
      out_load   = 1'b0;
      out_mask   = '0;
      out_mvalid = 1'b0;
      out_et     = '0;
      out_rt     = '0;
      out_err    = terr_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               if (q_head.op == OP_CLEAR) begin
                  sweep_in = '0;
                  state_in = B_CLEAR;
               end else begin
                  state_in = B_FETCH;
               end
            end
         end
         // counter read data lands in exp_rd_ff / rank_rd_ff
         B_FETCH: state_in = B_EXEC;
         B_EXEC: begin
            unique case (cmd_ff.op)
               OP_ROUTE: begin
                  if (!cmd_ff.token_end || out_free) begin
                     exp_we   = cmd_ff.upd;
                     rank_we  = cmd_ff.upd && !seen_ff[rank_addr];
                     state_in = B_IDLE;
                     if (cmd_ff.token_end) begin
                        out_load   = 1'b1;
                        out_mask   = mask_wide[15:0];
                        out_mvalid = 1'b1;
                        out_err    = terr_next;
                        seen_in    = '0;
                        terr_in    = 1'b0;
                     end else begin
                        seen_in = seen_next;
                        terr_in = terr_next;
                     end
                  end
               end
               OP_READ: begin
                  if (out_free) begin
                     out_load = 1'b1;
                     out_et   = (exp_idx32 < MAX_EXPERTS) ? 32'(exp_rd_ff) : '0;
                     out_rt   = (rank_idx32 < MAX_RANKS) ? 32'(rank_rd_ff) : '0;
                     state_in = B_IDLE;
                  end
               end
               default: state_in = B_IDLE;
            endcase
         end
         B_CLEAR: begin
            exp_wa  = sweep32[EXP_AW-1:0];
            rank_wa = sweep32[RANK_AW-1:0];
            exp_wd  = '0;
            rank_wd = '0;
            exp_we  = sweep32 < MAX_EXPERTS;
            rank_we = sweep32 < MAX_RANKS;
            if (sweep_ff == SW_W'(CLR_N - 1)) begin
               state_in = B_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      exp_rd_ff  <= expert_mem[exp_addr];
      rank_rd_ff <= rank_mem[rank_addr];
      if (exp_we) begin
         expert_mem[exp_wa] <= exp_wd;
      end
      if (rank_we) begin
         rank_mem[rank_wa] <= rank_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         sweep_ff     <= '0;
         seen_ff      <= '0;
         terr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         seen_ff      <= seen_in;
         terr_ff      <= terr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      if (out_load) begin
         rsp_mask_ff   <= out_mask;
         rsp_mvalid_ff <= out_mvalid;
         rsp_et_ff     <= out_et;
         rsp_rt_ff     <= out_rt;
         rsp_err_ff    <= out_err;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.rank_mask    = rsp_mask_ff;
   assign rsp_ch.mask_valid   = rsp_mvalid_ff;
   assign rsp_ch.expert_tally = rsp_et_ff;
   assign rsp_ch.rank_tally   = rsp_rt_ff;
   assign rsp_ch.range_error  = rsp_err_ff;

   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("pending result overwritten");

   a_mask_no_tally: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mvalid_ff |-> rsp_et_ff == '0 && rsp_rt_ff == '0)
      else $error("token result carries tallies");

   a_read_no_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_mvalid_ff |-> rsp_mask_ff == '0)
      else $error("read result carries a rank mask");

endmodule
